// File: src/longest_unique_window_unit_assert.svh
// Assertion macros for the longest unique window RTL.
`ifndef LONGEST_UNIQUE_WINDOW_UNIT_ASSERT_SVH
`define LONGEST_UNIQUE_WINDOW_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante, outside reset.
`define LUNW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define LUNW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/lunw_pkg.sv
// Shared constants, types and table access structs for the longest unique window unit.
package lunw_pkg;

    localparam int POS_BITS    = 16;
    localparam int CODE_BITS   = 8;
    localparam int LEN_BITS    = 9;
    localparam int START_BITS  = 16;
    localparam int TABLE_DEPTH = 1 << CODE_BITS;

    typedef logic [POS_BITS-1:0]   pos_t;
    typedef logic [CODE_BITS-1:0]  code_t;
    typedef logic [LEN_BITS-1:0]   len_t;
    typedef logic [START_BITS-1:0] start_t;

    localparam pos_t POS_MAX = '1;
    localparam len_t LEN_CAP = len_t'(TABLE_DEPTH);

    // Write side of the position table.
    typedef struct packed {
        logic  en;
        logic  clear;
        code_t code;
        pos_t  pos;
    } tbl_wr_t;

    // Lookup result, registered from the read and valid in the cycle after it.
    typedef struct packed {
        logic hit;
        pos_t prev;
    } tbl_rd_t;

endpackage

// File: src/lunw_if.sv
// Valid/ready channel interfaces for byte requests and window results.
interface lunw_in_if import lunw_pkg::*;;
    logic  valid;
    logic  ready;
    code_t char_code;
    logic  last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface lunw_out_if import lunw_pkg::*;;
    logic   valid;
    logic   ready;
    len_t   best_length;
    start_t best_start;
    logic   too_long;

    modport source (output valid, output best_length, output best_start, output too_long,
                    input ready);
    modport sink   (input valid, input best_length, input best_start, input too_long,
                    output ready);
endinterface

// File: src/longest_unique_window_unit.sv
// Top level of the longest unique window unit: window tracking and result register.
//
//   channel  | dir | payload                              | handshake
//   ---------+-----+--------------------------------------+-------------
//   feed     | in  | char_code[7:0], last_char            | valid/ready
//   result   | out | best_length[8:0], best_start[15:0],  | valid/ready
//            |     | too_long                             |
//
// One byte per cycle while no final byte waits; a result is registered when its final byte leaves the stage.
// The table memory is read when a byte is taken and written in the cycle after; a final byte clears valid bits.
// Reset clears control state and all table valid bits at once; no clearing pass.
// A final byte waits in the stage only while an earlier result is still unread.
`include "longest_unique_window_unit_assert.svh"

module longest_unique_window_unit import lunw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lunw_in_if.sink    feed,
    lunw_out_if.source result
);

    logic    s_valid_reg, s_valid_next;
    logic    s_last_reg;
    code_t   s_code_reg;
    pos_t    pos_reg, pos_next;
    pos_t    ws_reg, ws_next;
    len_t    best_len_reg, best_len_next;
    pos_t    best_begin_reg, best_begin_next;
    logic    ovf_reg, ovf_next;
    logic    out_valid_reg, out_valid_next;
    len_t    out_len_reg;
    start_t  out_start_reg;
    logic    out_ovf_reg;

    logic    accept;
    logic    fire;
    tbl_wr_t wr;
    tbl_rd_t lk;
    pos_t    next_start;
    pos_t    ws_new;
    pos_t    span;
    len_t    len_new;
    logic    better;
    len_t    len_upd;
    pos_t    begin_upd;

    assign fire       = s_valid_reg && (!s_last_reg || !out_valid_reg || result.ready);
    assign feed.ready = !s_valid_reg || fire;
    assign accept     = feed.valid && feed.ready;

    lunw_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_code (feed.char_code),
        .wr      (wr),
        .rd      (lk)
    );

    always_comb
    begin
        wr.en    = fire && !s_last_reg;
        wr.clear = fire && s_last_reg;
        wr.code  = s_code_reg;
        wr.pos   = pos_reg;
    end

    // Window update for the byte in the stage.
    always_comb
    begin
        next_start = (lk.prev == POS_MAX) ? POS_MAX : lk.prev + pos_t'(1);
        ws_new     = (lk.hit && (next_start > ws_reg)) ? next_start : ws_reg;
        span       = pos_reg - ws_new;
        if (ws_new > pos_reg)
        begin
            len_new = len_t'(1);
        end
        else if (span >= pos_t'(LEN_CAP - len_t'(1)))
        begin
            len_new = LEN_CAP;
        end
        else
        begin
            len_new = len_t'(span) + len_t'(1);
        end
        better    = len_new > best_len_reg;
        len_upd   = better ? len_new : best_len_reg;
        begin_upd = better ? ws_new : best_begin_reg;
    end

    always_comb
    begin
        s_valid_next    = s_valid_reg;
        pos_next        = pos_reg;
        ws_next         = ws_reg;
        best_len_next   = best_len_reg;
        best_begin_next = best_begin_reg;
        ovf_next        = ovf_reg;
        out_valid_next  = out_valid_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            s_valid_next = 1'b0;
            if (s_last_reg)
            begin
                out_valid_next  = 1'b1;
                pos_next        = '0;
                ws_next         = '0;
                best_len_next   = '0;
                best_begin_next = '0;
                ovf_next        = 1'b0;
            end
            else
            begin
                ws_next         = ws_new;
                best_len_next   = len_upd;
                best_begin_next = begin_upd;
                // saturate the position counter
                if (pos_reg == POS_MAX)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + pos_t'(1);
                end
            end
        end
        if (accept)
        begin
            s_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg    <= 1'b0;
            pos_reg        <= '0;
            ws_reg         <= '0;
            best_len_reg   <= '0;
            best_begin_reg <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            s_valid_reg    <= s_valid_next;
            pos_reg        <= pos_next;
            ws_reg         <= ws_next;
            best_len_reg   <= best_len_next;
            best_begin_reg <= best_begin_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_code_reg <= feed.char_code;
            s_last_reg <= feed.last_char;
        end
        if (fire && s_last_reg)
        begin
            out_len_reg   <= len_upd;
            out_start_reg <= start_t'(begin_upd);
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.best_length = out_len_reg;
    assign result.best_start  = out_start_reg;
    assign result.too_long    = out_ovf_reg;

    `LUNW_ASSERT_NOW(a_ws_not_past_pos, 1'b1, ws_reg <= pos_reg, "window start passed position")
    `LUNW_ASSERT_NOW(a_len_capped, 1'b1, best_len_reg <= LEN_CAP, "best length above cap")
    `LUNW_ASSERT_NOW(a_ovf_saturated, ovf_reg, pos_reg == POS_MAX, "overflow without saturation")
    `LUNW_ASSERT_NEXT(a_final_clears, fire && s_last_reg,
        (pos_reg == '0) && (best_len_reg == '0) && out_valid_reg, "final byte left state")
    `LUNW_ASSERT_NOW(a_result_nonzero, out_valid_reg, out_len_reg != '0, "empty result length")

endmodule

// File: src/lunw_table.sv
// Last-position table: synchronous memory, valid bits and write-to-read forwarding.
module lunw_table import lunw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    rd_en,
    input  code_t   rd_code,
    input  tbl_wr_t wr,
    output tbl_rd_t rd
);

    pos_t                   mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    pos_t                   rdata_reg;
    code_t                  code_reg;
    logic                   fwd_reg;
    pos_t                   fwd_pos_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.code] <= wr.pos;
        end
        if (rd_en)
        begin
            rdata_reg   <= mem[rd_code];
            code_reg    <= rd_code;
            fwd_pos_reg <= wr.pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            if (wr.clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wr.code] <= 1'b1;
            end
            // the memory read misses a write landing on the same edge: take it here
            if (rd_en)
            begin
                fwd_reg <= wr.en && (wr.code == rd_code);
            end
        end
    end

    assign rd.hit  = fwd_reg | valid_reg[code_reg];
    assign rd.prev = fwd_reg ? fwd_pos_reg : rdata_reg;

endmodule
